// ===== hdl/assert_macros.svh =====
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms for the RTL folder.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge, off while reset is low
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check with the block's usual clock and reset names
`define ASSERT_STD(lbl, prop, msg) `ASSERT_CLK(lbl, i_clk, i_rst_n, prop, msg)

`endif

// ===== hdl/lrp_pkg.sv =====
// ============================================================================
// lrp_pkg
// Shared codes, widths and control types of the LRU replacement block.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package lrp_pkg;

    // Default pool size
    localparam int FRAMES_DEF = 16;

    // Field widths
    localparam int OP_W     = 3;
    localparam int FRAME_W  = 4;
    localparam int PIN_W    = 8;
    localparam int STATUS_W = 2;
    localparam int VICT_W   = 4;
    localparam int OCC_W    = 5;

    // Packed stream widths
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;
    localparam int OUT_PAD    = OUT_DATA_W - (STATUS_W + VICT_W + OCC_W);

    // Operation codes
    localparam logic [OP_W-1:0] OP_ADD   = 3'd0;
    localparam logic [OP_W-1:0] OP_FIND  = 3'd1;
    localparam logic [OP_W-1:0] OP_TOUCH = 3'd2;
    localparam logic [OP_W-1:0] OP_EVICT = 3'd3;
    localparam logic [OP_W-1:0] OP_PIN   = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic scan_step;
        logic exec;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic in_evict;
        logic scan_last;
    } t_sts;

endpackage

`default_nettype wire

// ===== hdl/lru_replacement_with_pins.sv =====
// ============================================================================
// lru_replacement_with_pins
// Recency list over a pool of buffer frames with per-frame pin counts.
// ============================================================================
// Usage:
//   Requests arrive on the slave stream (i_s_*): one beat per operation,
//   tdata = {pin_value, frame, op}. Every request yields exactly one result
//   beat on the master stream (o_m_*): tdata = {occupancy, victim, status}.
//   One request is in work at a time. Add, find, touch, set pin and unused
//   codes pass through accept and execute; the result is valid the cycle
//   after execute. Evict runs the victim scan between accept and execute;
//   the scan reads one frame cell per cycle.
//   A new request is taken as soon as the block returns to idle, even while
//   the previous result still waits in the output register.
//   If the receiver stalls, the next request executes only once the output
//   register is free; until then o_s_tready stays low.
//   Reset (synchronous, active low) empties the list and clears all ranks
//   and pin counts at once; no clearing pass is needed.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module lru_replacement_with_pins
    import lrp_pkg::*;
#(
    parameter int FRAMES = FRAMES_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    // [2:0] op, [6:3] frame, [14:7] pin_value, [15] zero
    input  wire logic [IN_DATA_W-1:0]  i_s_tdata,
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    // [1:0] status, [5:2] victim, [10:6] occupancy, [15:11] zero
    output logic [OUT_DATA_W-1:0]      o_m_tdata
);

    t_cmd w_cmd;
    t_sts w_sts;

    // Sequencer
    lrp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Frame table and result
    lrp_datapath #(
        .FRAMES (FRAMES)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tdata (i_s_tdata),
        .i_cmd     (w_cmd),
        .o_sts     (w_sts),
        .o_m_tdata (o_m_tdata)
    );

endmodule

`default_nettype wire

// ===== hdl/lrp_datapath.sv =====
// ============================================================================
// lrp_datapath
// Frame table (rank, listed flag, pin count), victim scan and result register.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module lrp_datapath
    import lrp_pkg::*;
#(
    parameter int FRAMES = FRAMES_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic [IN_DATA_W-1:0]  i_s_tdata,
    input  wire t_cmd                  i_cmd,
    output t_sts                       o_sts,
    output logic [OUT_DATA_W-1:0]      o_m_tdata
);

    localparam int IDX_W  = $clog2(FRAMES);
    localparam int SIZE_W = $clog2(FRAMES + 1);

    // Frame cells
    logic [IDX_W-1:0]  r_rank   [FRAMES];
    logic [FRAMES-1:0] r_listed;
    logic [PIN_W-1:0]  r_pin    [FRAMES];
    logic [SIZE_W-1:0] r_size;
    logic [IDX_W-1:0]  n_rank   [FRAMES];
    logic [FRAMES-1:0] n_listed;
    logic [SIZE_W-1:0] n_size;

    // Latched request
    logic [OP_W-1:0]    r_op;
    logic [FRAME_W-1:0] r_frame;
    logic [PIN_W-1:0]   r_pinv;

    // Victim scan
    logic [IDX_W-1:0] r_idx;
    logic             r_found;
    logic [IDX_W-1:0] r_best;
    logic [IDX_W-1:0] r_best_rank;

    // Result register
    logic [STATUS_W-1:0] r_status;
    logic [VICT_W-1:0]   r_victim;
    logic [OCC_W-1:0]    r_occ;

    logic [IDX_W-1:0]    w_fidx;
    logic                w_inrange;
    logic [IDX_W-1:0]    w_addr;
    logic [IDX_W-1:0]    w_rd_rank;
    logic                w_rd_listed;
    logic                w_cand;
    logic                w_do_mtf;
    logic                w_do_ins;
    logic                w_do_unl;
    logic                w_do_pin;
    logic [STATUS_W-1:0] w_status;
    logic [IDX_W-1:0]    w_key;
    logic [IDX_W-1:0]    w_kr;

    // Address the table at the scan index or at the requested frame
    assign w_fidx      = IDX_W'(r_frame);
    assign w_inrange   = (32'(r_frame) < FRAMES);
    assign w_addr      = i_cmd.scan_step ? r_idx : w_fidx;
    assign w_rd_rank   = r_rank[w_addr];
    assign w_rd_listed = r_listed[w_addr];
    assign w_cand      = w_rd_listed && (r_pin[w_addr] == '0) &&
                         (!r_found || (w_rd_rank > r_best_rank));

    // Status toward the controller
    assign o_sts.in_evict  = (i_s_tdata[OP_W-1:0] == OP_EVICT);
    assign o_sts.scan_last = (r_idx == IDX_W'(FRAMES - 1));

    // Decode the latched operation
    always_comb begin
        w_do_mtf = 1'b0;
        w_do_ins = 1'b0;
        w_do_unl = 1'b0;
        w_do_pin = 1'b0;
        w_status = ST_OK;
        case (r_op) inside
            OP_ADD: begin
                if (!w_inrange) begin
                    w_status = ST_NOTFOUND;
                end else if (w_rd_listed) begin
                    w_do_mtf = 1'b1;
                end else begin
                    w_do_ins = 1'b1;
                end
            end
            OP_FIND, OP_TOUCH: begin
                if (r_size == '0) begin
                    w_status = ST_EMPTY;
                end else if (!w_inrange || !w_rd_listed) begin
                    w_status = ST_NOTFOUND;
                end else if (r_op == OP_TOUCH) begin
                    w_do_mtf = 1'b1;
                end
            end
            OP_EVICT: begin
                if (r_found) begin
                    w_do_unl = 1'b1;
                end else begin
                    w_status = ST_NOTFOUND;
                end
            end
            OP_PIN: begin
                if (w_inrange) begin
                    w_do_pin = 1'b1;
                end else begin
                    w_status = ST_NOTFOUND;
                end
            end
            default: begin
            end
        endcase
    end

    assign w_key = w_do_unl ? r_best : w_fidx;
    assign w_kr  = w_do_unl ? r_best_rank : w_rd_rank;

    // Shift ranks of every cell in parallel around the key frame
    always_comb begin
        for (int i = 0; i < FRAMES; i++) begin
            n_rank[i]   = r_rank[i];
            n_listed[i] = r_listed[i];
            if (r_listed[i]) begin
                if (w_do_ins || (w_do_mtf && (r_rank[i] < w_kr))) begin
                    n_rank[i] = r_rank[i] + 1'b1;
                end else if (w_do_unl && (r_rank[i] > w_kr)) begin
                    n_rank[i] = r_rank[i] - 1'b1;
                end
            end
            if (IDX_W'(i) == w_key) begin
                if (w_do_ins || w_do_mtf) begin
                    n_rank[i]   = '0;
                    n_listed[i] = 1'b1;
                end else if (w_do_unl) begin
                    n_rank[i]   = '0;
                    n_listed[i] = 1'b0;
                end
            end
        end
        n_size = r_size;
        if (w_do_ins) begin
            n_size = r_size + 1'b1;
        end else if (w_do_unl) begin
            n_size = r_size - 1'b1;
        end
    end

    // Hold the frame table; apply one operation per exec
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_listed <= '0;
            r_size   <= '0;
            for (int i = 0; i < FRAMES; i++) begin
                r_rank[i] <= '0;
                r_pin[i]  <= '0;
            end
        end else if (i_cmd.exec) begin
            r_listed <= n_listed;
            r_size   <= n_size;
            for (int i = 0; i < FRAMES; i++) begin
                r_rank[i] <= n_rank[i];
            end
            if (w_do_pin) begin
                r_pin[w_fidx] <= r_pinv;
            end
        end
    end

    // Latch the request, advance the scan, capture the result
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_s_tdata[OP_W-1:0];
            r_frame <= i_s_tdata[OP_W +: FRAME_W];
            r_pinv  <= i_s_tdata[OP_W + FRAME_W +: PIN_W];
            r_idx   <= '0;
            r_found <= 1'b0;
        end else if (i_cmd.scan_step) begin
            r_idx <= r_idx + 1'b1;
            if (w_cand) begin
                r_found     <= 1'b1;
                r_best      <= r_idx;
                r_best_rank <= w_rd_rank;
            end
        end
        if (i_cmd.exec) begin
            r_status <= w_status;
            r_victim <= w_do_unl ? VICT_W'(r_best) : '0;
            r_occ    <= OCC_W'(n_size);
        end
    end

    assign o_m_tdata = {{OUT_PAD{1'b0}}, r_occ, r_victim, r_status};

    // Checks
    `ASSERT_STD(a_size_bound, 1'b1 |-> (32'(r_size) <= FRAMES), "list size above pool size")
    `ASSERT_STD(a_evict_shrinks, (i_cmd.exec && (r_op == OP_EVICT) && r_found) |=> (r_size == $past(r_size) - 1'b1), "evict did not shrink list")

endmodule

`default_nettype wire

// ===== hdl/lrp_ctrl.sv =====
// ============================================================================
// lrp_ctrl
// Sequencer for accept, victim scan and execute; owns the output valid.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module lrp_ctrl
    import lrp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_s_tvalid,
    output logic      o_s_tready,
    output logic      o_m_tvalid,
    input  wire logic i_m_tready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       w_accept;
    logic       w_slot_free;

    // Take a request only in idle and never while reset is low
    assign o_s_tready  = i_rst_n && (r_state == S_IDLE);
    assign w_accept    = i_s_tvalid && o_s_tready;
    assign w_slot_free = !r_out_valid || i_m_tready;

    // Commands toward the datapath
    assign o_cmd.load      = w_accept;
    assign o_cmd.scan_step = (r_state == S_SCAN);
    assign o_cmd.exec      = (r_state == S_EXEC) && w_slot_free;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = i_sts.in_evict ? S_SCAN : S_EXEC;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_last) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.exec) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;

    // Checks
    `ASSERT_STD(a_accept_leaves_idle, w_accept |=> (r_state != S_IDLE),
                "accept did not start work")
    `ASSERT_STD(a_exec_sets_valid, o_cmd.exec |=> r_out_valid, "executed beat not presented")
    `ASSERT_STD(a_scan_only_evict,
                ((r_state == S_IDLE) && w_accept && !i_sts.in_evict) |=> (r_state == S_EXEC),
                "scan entered for non-evict")

endmodule

`default_nettype wire
